FILE: sv/text_console_writer_top_defines.svh
// ----------------------------------------------------------------------------
// text_console_writer_top_defines.svh
// Assertion macros used by the console writer top level.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_TOP_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define TCW_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define TCW_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Types and constants for the text console writer.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

	localparam int unsigned COLUMNS_DEF = 80;
	localparam int unsigned ROWS_DEF    = 25;

	localparam logic [7:0] NEWLINE_CODE = 8'h0A;
	localparam logic [7:0] BLANK_CODE   = 8'h20;
	localparam logic [7:0] RESET_COLOR  = 8'h0F;

	// word index of the attribute register
	localparam logic REG_TEXT_COLOR = 1'b0;

	typedef enum logic {
		OP_PUT  = 1'b0,
		OP_READ = 1'b1
	} tcw_op_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_EXEC,
		ST_RESP,
		ST_SCROLL
	} tcw_state_t;

	typedef struct packed {
		logic take_item;
		logic exec;
		logic load_result;
		logic init_clear;
		logic row_clear;
	} tcw_cmd_t;

	typedef struct packed {
		logic scroll;
		logic init_done;
		logic row_done;
		logic out_busy;
	} tcw_status_t;

endpackage

`default_nettype wire

FILE: sv/text_console_writer_top.sv
// ----------------------------------------------------------------------------
// text_console_writer_top
// Text console engine: screen RAM of character cells plus a cursor.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_*: s_tuser is the op (0 put, 1 read); s_tdata carries the
//   character, read row and read column. Every transfer yields exactly one
//   result on m_*: cursor position, row, column, read cell, scroll flag.
//   The APB port holds text_color, the attribute byte for written cells.
//   Each item passes an exec step and a response step, set by the single
//   RAM port (address, then the registered read); while the result register
//   stays free, the next item is taken in the response step.
//   A put that scrolls the screen is followed by a clear of the new bottom
//   row; no input is taken meanwhile. Rows live in a ring, so a scroll
//   moves no data.
//   After reset the whole screen is written to 0x0F20, cell by cell, with
//   s_tready low; APB writes are taken throughout.
//   A stalled m_tready holds the result; one further item may be accepted
//   and executed, then s_tready drops until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

`include "text_console_writer_top_defines.svh"

module text_console_writer_top #(
	parameter int unsigned COLUMNS = tcw_pkg::COLUMNS_DEF,
	parameter int unsigned ROWS    = tcw_pkg::ROWS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// APB configuration
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	// input stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,  // char_code[7:0], read_row[12:8], read_col[19:13]
	input  wire logic        s_tuser,  // op[0]
	// result stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [39:0] m_tdata   // cursor_pos[10:0], cursor_row[15:11],
	                                   // cursor_col[22:16], cell_data[38:23], scrolled[39]
);

	import tcw_pkg::*;

	tcw_cmd_t    cmd;
	tcw_status_t status;

	logic [7:0]  text_color_q;
	logic        reg_wr;
	logic [10:0] cursor_pos;
	logic [4:0]  cursor_row;
	logic [6:0]  cursor_col;
	logic [15:0] cell_data;
	logic        scrolled;

	assign pready = 1'b1;
	assign reg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_TEXT_COLOR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_color_q <= RESET_COLOR;
		end else if (reg_wr) begin
			text_color_q <= pwdata[7:0];
		end
	end

	assign prdata = (paddr[2] == REG_TEXT_COLOR) ? {24'h0, text_color_q} : 32'h0;

	tcw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.out_ready(m_tready),
		.status   (status),
		.cmd      (cmd)
	);

	tcw_dp #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.text_color(text_color_q),
		.in_op     (s_tuser),
		.in_char   (s_tdata[7:0]),
		.in_row    (s_tdata[12:8]),
		.in_col    (s_tdata[19:13]),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.cursor_pos(cursor_pos),
		.cursor_row(cursor_row),
		.cursor_col(cursor_col),
		.cell_data (cell_data),
		.scrolled  (scrolled)
	);

	assign m_tdata = {scrolled, cell_data, cursor_col, cursor_row, cursor_pos};

	`TCW_ASSERT_NOW(a_no_take_in_clear, cmd.init_clear || cmd.row_clear, !s_tready,
		"input accepted while the screen is being cleared")
	`TCW_ASSERT_NEXT(a_take_then_exec, s_tvalid && s_tready, cmd.exec,
		"accepted item not executed in the next cycle")
	`TCW_ASSERT_NEXT(a_load_shows_valid, cmd.load_result, m_tvalid,
		"result loaded but not presented")
	`TCW_ASSERT_NEXT(a_scroll_row_last, cmd.load_result && status.scroll,
		m_tdata[39] && (m_tdata[22:16] == 7'd0),
		"scrolled result must leave the cursor at column zero")

endmodule

`default_nettype wire

FILE: sv/tcw_ram.sv
// ----------------------------------------------------------------------------
// tcw_ram
// Single-port RAM, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 2000
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[addr];
		end
	end

endmodule

`default_nettype wire

FILE: sv/tcw_ctrl.sv
// ----------------------------------------------------------------------------
// tcw_ctrl
// Sequencer: screen clear after reset, item execution, scroll row clear.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic                out_ready,
	input  wire tcw_pkg::tcw_status_t status,
	output tcw_pkg::tcw_cmd_t        cmd
);

	import tcw_pkg::*;

	tcw_state_t state_q;
	tcw_state_t state_nxt;
	logic       slot_free;

	assign slot_free = !status.out_busy || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		unique case (state_q)
			ST_INIT: begin
				cmd.init_clear = 1'b1;
				if (status.init_done) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take_item = 1'b1;
					state_nxt     = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec  = 1'b1;
				state_nxt = ST_RESP;
			end
			ST_RESP: begin
				if (slot_free) begin
					cmd.load_result = 1'b1;
					if (status.scroll) begin
						state_nxt = ST_SCROLL;
					end else begin
						in_ready = 1'b1;
						if (in_valid) begin
							cmd.take_item = 1'b1;
							state_nxt     = ST_EXEC;
						end else begin
							state_nxt = ST_IDLE;
						end
					end
				end
			end
			ST_SCROLL: begin
				cmd.row_clear = 1'b1;
				if (status.row_done) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: sv/tcw_dp.sv
// ----------------------------------------------------------------------------
// tcw_dp
// Datapath: cursor, ring row offset, address generation, screen RAM, result.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_dp #(
	parameter int unsigned COLUMNS = tcw_pkg::COLUMNS_DEF,
	parameter int unsigned ROWS    = tcw_pkg::ROWS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire tcw_pkg::tcw_cmd_t cmd,
	output tcw_pkg::tcw_status_t   status,
	input  wire logic [7:0]        text_color,
	input  wire logic              in_op,
	input  wire logic [7:0]        in_char,
	input  wire logic [4:0]        in_row,
	input  wire logic [6:0]        in_col,
	input  wire logic              out_ready,
	output logic                   out_valid,
	output logic      [10:0]       cursor_pos,
	output logic      [4:0]        cursor_row,
	output logic      [6:0]        cursor_col,
	output logic      [15:0]       cell_data,
	output logic                   scrolled
);

	import tcw_pkg::*;

	localparam int unsigned DEPTH = ROWS * COLUMNS;
	localparam int unsigned RW    = $clog2(ROWS);
	localparam int unsigned CW    = $clog2(COLUMNS);
	localparam int unsigned AW    = $clog2(DEPTH);

	// accepted item
	tcw_op_t      op_q;
	logic [7:0]   char_q;
	logic [4:0]   rrow_q;
	logic [6:0]   rcol_q;

	// cursor and ring offset of the top row
	logic [RW-1:0] cur_row_q;
	logic [CW-1:0] cur_col_q;
	logic [RW-1:0] top_q;

	logic          scroll_q;
	logic          rd_ok_q;
	logic [7:0]    scroll_color_q;
	logic [AW-1:0] clr_addr_q;
	logic [CW-1:0] clr_cnt_q;

	logic          out_valid_q;
	logic [10:0]   pos_q;
	logic [4:0]    row_q;
	logic [6:0]    col_q;
	logic [15:0]   cell_q;
	logic          scrolled_q;

	logic          is_read;
	logic          is_nl;
	logic [CW:0]   col_inc;
	logic          col_wrap;
	logic          row_adv;
	logic [RW:0]   row_inc;
	logic          scroll_now;
	logic          rd_ok;
	logic [RW-1:0] sel_row;
	logic [CW-1:0] sel_col;
	logic [RW:0]   phys_sum;
	logic [RW-1:0] phys_row;
	logic [AW-1:0] cell_addr;
	logic [AW-1:0] top_base;
	logic [RW:0]   top_inc;
	logic [RW-1:0] top_next;
	logic [AW-1:0] pos_full;

	logic          ram_we;
	logic          ram_re;
	logic [AW-1:0] ram_addr;
	logic [15:0]   ram_wdata;
	logic [15:0]   ram_rdata;

	assign is_read    = (op_q == OP_READ);
	assign is_nl      = (char_q == NEWLINE_CODE);
	assign col_inc    = (CW+1)'(cur_col_q) + (CW+1)'(1);
	assign col_wrap   = (col_inc >= (CW+1)'(COLUMNS));
	assign row_adv    = is_nl || col_wrap;
	assign row_inc    = (RW+1)'(cur_row_q) + (RW+1)'(1);
	assign scroll_now = !is_read && row_adv && (row_inc >= (RW+1)'(ROWS));
	assign rd_ok      = (32'(rrow_q) < ROWS) && (32'(rcol_q) < COLUMNS);

	assign sel_row   = is_read ? RW'(rrow_q) : cur_row_q;
	assign sel_col   = is_read ? CW'(rcol_q) : cur_col_q;
	assign phys_sum  = (RW+1)'(sel_row) + (RW+1)'(top_q);
	assign phys_row  = (phys_sum >= (RW+1)'(ROWS)) ? RW'(phys_sum - (RW+1)'(ROWS))
	                                               : RW'(phys_sum);
	assign cell_addr = AW'(phys_row) * AW'(COLUMNS) + AW'(sel_col);
	assign top_base  = AW'(top_q) * AW'(COLUMNS);
	assign top_inc   = (RW+1)'(top_q) + (RW+1)'(1);
	assign top_next  = (top_inc == (RW+1)'(ROWS)) ? '0 : RW'(top_inc);
	assign pos_full  = AW'(cur_row_q) * AW'(COLUMNS) + AW'(cur_col_q);

	always_comb begin
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_addr  = cell_addr;
		ram_wdata = {text_color, char_q};
		if (cmd.init_clear) begin
			ram_we    = 1'b1;
			ram_addr  = clr_addr_q;
			ram_wdata = {RESET_COLOR, BLANK_CODE};
		end else if (cmd.row_clear) begin
			ram_we    = 1'b1;
			ram_addr  = clr_addr_q;
			ram_wdata = {scroll_color_q, BLANK_CODE};
		end else if (cmd.exec) begin
			ram_we = !is_read && !is_nl;
			ram_re = is_read;
		end
	end

	tcw_ram #(
		.WIDTH(16),
		.DEPTH(DEPTH)
	) u_screen (
		.clk  (clk),
		.we   (ram_we),
		.re   (ram_re),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.take_item) begin
			op_q   <= tcw_op_t'(in_op);
			char_q <= in_char;
			rrow_q <= in_row;
			rcol_q <= in_col;
		end
		if (cmd.exec && scroll_now) begin
			scroll_color_q <= text_color;
		end
		if (cmd.load_result) begin
			pos_q      <= 11'(pos_full);
			row_q      <= 5'(cur_row_q);
			col_q      <= 7'(cur_col_q);
			cell_q     <= rd_ok_q ? ram_rdata : '0;
			scrolled_q <= scroll_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_row_q   <= '0;
			cur_col_q   <= '0;
			top_q       <= '0;
			scroll_q    <= 1'b0;
			rd_ok_q     <= 1'b0;
			clr_addr_q  <= '0;
			clr_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.init_clear || cmd.row_clear) begin
				clr_addr_q <= clr_addr_q + AW'(1);
			end
			if (cmd.row_clear) begin
				clr_cnt_q <= clr_cnt_q + CW'(1);
			end
			if (cmd.exec) begin
				scroll_q <= scroll_now;
				rd_ok_q  <= is_read && rd_ok;
				if (!is_read) begin
					if (row_adv) begin
						cur_col_q <= '0;
						cur_row_q <= scroll_now ? RW'(ROWS - 1) : RW'(row_inc);
					end else begin
						cur_col_q <= CW'(col_inc);
					end
				end
				if (scroll_now) begin
					top_q      <= top_next;
					clr_addr_q <= top_base;
					clr_cnt_q  <= '0;
				end
			end
			if (cmd.load_result) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign status.scroll    = scroll_q;
	assign status.init_done = (clr_addr_q == AW'(DEPTH - 1));
	assign status.row_done  = (clr_cnt_q == CW'(COLUMNS - 1));
	assign status.out_busy  = out_valid_q;

	assign out_valid  = out_valid_q;
	assign cursor_pos = pos_q;
	assign cursor_row = row_q;
	assign cursor_col = col_q;
	assign cell_data  = cell_q;
	assign scrolled   = scrolled_q;

endmodule

`default_nettype wire
